@@ hw/rtl/murmur3_byte_stream_hash_unit_defines.svh @@
// ---------------------------------------------------------------------------
// murmur3 byte stream hash unit: assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef MURMUR3_BYTE_STREAM_HASH_UNIT_DEFINES_SVH
`define MURMUR3_BYTE_STREAM_HASH_UNIT_DEFINES_SVH

// same-cycle implication on the local clock, off during reset
`define MMH_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on the local clock, off during reset
`define MMH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/mmh_pkg.sv @@
// ---------------------------------------------------------------------------
// mmh_pkg
// constants, commands, states and status shared by the hash unit
// ---------------------------------------------------------------------------
package mmh_pkg;

   localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2  = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
   localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

   localparam logic [1:0] PHASE_FULL = 2'd3;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_TAKE,
      CMD_MUL_C1,
      CMD_ROT_C2,
      CMD_FOLD,
      CMD_TAIL_C1,
      CMD_FIN_C1,
      CMD_FIN_C2
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    emit;
   } ctrl_type;

   typedef struct packed {
      logic out_stall;
      logic phase_full;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLK1,
      ST_BLK2,
      ST_BLK3,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3,
      ST_FIN4,
      ST_EMIT
   } state_type;

endpackage

@@ hw/rtl/mmh_datapath.sv @@
// ---------------------------------------------------------------------------
// mmh_datapath
// hash state, shared multiplier and output register
// ---------------------------------------------------------------------------
module mmh_datapath (
   input  logic              clock,
   input  logic              reset,
   input  mmh_pkg::ctrl_type ctrl,
   output mmh_pkg::stat_type stat,
   input  logic [7:0]        req_data_byte,
   input  logic              req_has_byte,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   output logic [31:0]       rsp_hash,
   output logic              rsp_valid,
   input  logic              rsp_ready
);

   logic [31:0] seed_ff, seed_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] work_ff, work_in;
   logic [23:0] part_ff, part_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] len_ff, len_in;
   logic        busy_ff, busy_in;
   logic [31:0] out_ff, out_in;
   logic        out_vld_ff, out_vld_in;

   logic [31:0] mul_a, mul_b, mul_prod;
   logic [31:0] fold_x, fold_r, fin_f, fin_g;

   assign mul_prod = mul_a * mul_b;

   assign fold_x = hash_ff ^ work_ff;
   assign fold_r = {fold_x[18:0], fold_x[31:19]};
   // tail word only counts when bytes are left over
   assign fin_f  = hash_ff ^ ((phase_ff != 2'd0) ? work_ff : 32'd0) ^ len_ff;
   assign fin_g  = fin_f ^ (fin_f >> 16);

   always_comb begin
      mul_a = work_ff;
      mul_b = mmh_pkg::MIX_C1;
      case (ctrl.cmd)
         mmh_pkg::CMD_MUL_C1: begin
            mul_a = work_ff;
            mul_b = mmh_pkg::MIX_C1;
         end
         mmh_pkg::CMD_TAIL_C1: begin
            mul_a = {8'd0, part_ff};
            mul_b = mmh_pkg::MIX_C1;
         end
         mmh_pkg::CMD_ROT_C2: begin
            mul_a = {work_ff[16:0], work_ff[31:17]};
            mul_b = mmh_pkg::MIX_C2;
         end
         mmh_pkg::CMD_FIN_C1: begin
            mul_a = fin_g;
            mul_b = mmh_pkg::FIN_C1;
         end
         mmh_pkg::CMD_FIN_C2: begin
            mul_a = work_ff ^ (work_ff >> 13);
            mul_b = mmh_pkg::FIN_C2;
         end
         default: begin
            mul_a = work_ff;
            mul_b = mmh_pkg::MIX_C1;
         end
      endcase
   end

   always_comb begin
      seed_in    = seed_ff;
      hash_in    = hash_ff;
      work_in    = work_ff;
      part_in    = part_ff;
      phase_in   = phase_ff;
      len_in     = len_ff;
      busy_in    = busy_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_ready;

      if (csr_wr_en) begin
         seed_in = csr_wr_data;
         if (!busy_ff) begin
            hash_in = csr_wr_data;
         end
      end

      case (ctrl.cmd)
         mmh_pkg::CMD_TAKE: begin
            if (req_has_byte) begin
               busy_in = 1'b1;
               len_in  = len_ff + 32'd1;
               if (phase_ff == mmh_pkg::PHASE_FULL) begin
                  work_in  = {req_data_byte, part_ff};
                  part_in  = 24'd0;
                  phase_in = 2'd0;
               end else begin
                  case (phase_ff)
                     2'd0:    part_in[7:0]   = req_data_byte;
                     2'd1:    part_in[15:8]  = req_data_byte;
                     default: part_in[23:16] = req_data_byte;
                  endcase
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         mmh_pkg::CMD_MUL_C1, mmh_pkg::CMD_TAIL_C1, mmh_pkg::CMD_ROT_C2,
         mmh_pkg::CMD_FIN_C1, mmh_pkg::CMD_FIN_C2: begin
            work_in = mul_prod;
         end
         mmh_pkg::CMD_FOLD: begin
            // times five as shift and add
            hash_in = {fold_r[29:0], 2'b00} + fold_r + mmh_pkg::MIX_ADD;
         end
         default: begin
         end
      endcase

      if (ctrl.emit) begin
         out_in     = work_ff ^ (work_ff >> 16);
         out_vld_in = 1'b1;
         hash_in    = seed_ff;
         part_in    = 24'd0;
         phase_in   = 2'd0;
         len_in     = 32'd0;
         busy_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= 32'd0;
         hash_ff    <= 32'd0;
         part_ff    <= 24'd0;
         phase_ff   <= 2'd0;
         len_ff     <= 32'd0;
         busy_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         seed_ff    <= seed_in;
         hash_ff    <= hash_in;
         part_ff    <= part_in;
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         busy_ff    <= busy_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      out_ff  <= out_in;
   end

   assign stat.out_stall  = out_vld_ff && !rsp_ready;
   assign stat.phase_full = (phase_ff == mmh_pkg::PHASE_FULL);
   assign rsp_hash        = out_ff;
   assign rsp_valid       = out_vld_ff;

endmodule

@@ hw/rtl/mmh_ctrl.sv @@
// ---------------------------------------------------------------------------
// mmh_ctrl
// sequences byte intake, block mixing and finalization
// ---------------------------------------------------------------------------
module mmh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_has_byte,
   input  logic              req_last,
   output logic              req_ready,
   input  mmh_pkg::stat_type stat,
   output mmh_pkg::ctrl_type ctrl
);

   mmh_pkg::state_type state_ff, state_in;
   logic               last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmh_pkg::ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      ctrl.cmd  = mmh_pkg::CMD_NONE;
      ctrl.emit = 1'b0;
      case (state_ff)
         mmh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.cmd = mmh_pkg::CMD_TAKE;
               last_in  = req_last;
               if (req_has_byte && stat.phase_full) begin
                  state_in = mmh_pkg::ST_BLK1;
               end else if (req_last) begin
                  state_in = mmh_pkg::ST_FIN1;
               end
            end
         end
         mmh_pkg::ST_BLK1: begin
            ctrl.cmd = mmh_pkg::CMD_MUL_C1;
            state_in = mmh_pkg::ST_BLK2;
         end
         mmh_pkg::ST_BLK2: begin
            ctrl.cmd = mmh_pkg::CMD_ROT_C2;
            state_in = mmh_pkg::ST_BLK3;
         end
         mmh_pkg::ST_BLK3: begin
            ctrl.cmd = mmh_pkg::CMD_FOLD;
            state_in = last_ff ? mmh_pkg::ST_FIN1 : mmh_pkg::ST_IDLE;
         end
         mmh_pkg::ST_FIN1: begin
            ctrl.cmd = mmh_pkg::CMD_TAIL_C1;
            state_in = mmh_pkg::ST_FIN2;
         end
         mmh_pkg::ST_FIN2: begin
            ctrl.cmd = mmh_pkg::CMD_ROT_C2;
            state_in = mmh_pkg::ST_FIN3;
         end
         mmh_pkg::ST_FIN3: begin
            ctrl.cmd = mmh_pkg::CMD_FIN_C1;
            state_in = mmh_pkg::ST_FIN4;
         end
         mmh_pkg::ST_FIN4: begin
            ctrl.cmd = mmh_pkg::CMD_FIN_C2;
            state_in = mmh_pkg::ST_EMIT;
         end
         mmh_pkg::ST_EMIT: begin
            // wait for the output register to free up
            if (!stat.out_stall) begin
               ctrl.emit = 1'b1;
               state_in  = mmh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmh_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/murmur3_byte_stream_hash_unit.sv @@
// ---------------------------------------------------------------------------
// murmur3_byte_stream_hash_unit
// 32-bit murmur3 (x86) hash over a byte stream, at most one byte per item
// ---------------------------------------------------------------------------
// A byte that does not complete a 4-byte block is only taken in. The byte
// that completes a block is then scrambled and folded in through one shared
// 32x32 multiplier: multiply by c1, rotate and multiply by c2, then fold
// into the hash. An item marked last adds finalization (tail scramble and
// avalanche, again through the shared multiplier) plus any wait for the
// previous result to be taken; the input is held off during that work. A
// new seed takes effect at the next message; written between messages it
// also reloads the running hash at once.
module murmur3_byte_stream_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   input  logic        req_valid,
   output logic        req_ready,
   output logic [31:0] rsp_hash,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   mmh_pkg::ctrl_type ctrl;
   mmh_pkg::stat_type stat;

   mmh_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_has_byte (req_has_byte),
      .req_last     (req_last),
      .req_ready    (req_ready),
      .stat         (stat),
      .ctrl         (ctrl)
   );

   mmh_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_hash      (rsp_hash),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready)
   );

endmodule

@@ hw/rtl/mmh_checker.sv @@
// ---------------------------------------------------------------------------
// mmh_checker
// port-level checks for the hash unit, bound to the top level
// ---------------------------------------------------------------------------
`include "murmur3_byte_stream_hash_unit_defines.svh"

module mmh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hash
);

   logic out_wait;
   logic last_take;
   logic idle_quiet;

   assign out_wait   = rsp_valid && !rsp_ready;
   assign last_take  = req_valid && req_ready && req_last;
   assign idle_quiet = !rsp_valid && req_ready && !last_take;

   // a stalled result holds its value
   `MMH_ASSERT_NEXT(a_rsp_hold, out_wait, rsp_valid && $stable(rsp_hash), "stalled result changed")

   // finalization holds off the input
   `MMH_ASSERT_NEXT(a_last_busy, last_take, !req_ready, "input taken in finalization")

   // a new result only appears out of a busy period
   `MMH_ASSERT_NOW(a_rsp_origin, $rose(rsp_valid), !$past(req_ready), "unexpected new result")

   // no result while the input is free and nothing was pending
   `MMH_ASSERT_NEXT(a_no_spurious, idle_quiet, !rsp_valid, "unexpected result")

endmodule

bind murmur3_byte_stream_hash_unit mmh_checker u_mmh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_last  (req_last),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_hash  (rsp_hash)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// murmur3 byte stream hash unit testbench
// drives byte items and seed writes, predicts each 32-bit hash in the bench
// and checks every result in order, with random idling on both channels
// ---------------------------------------------------------------------------
module testbench;

   localparam logic [31:0] K_MUL1   = 32'hcc9e2d51;
   localparam logic [31:0] K_MUL2   = 32'h1b873593;
   localparam logic [31:0] K_ADD    = 32'he6546b64;
   localparam logic [31:0] K_FMIX1  = 32'h85ebca6b;
   localparam logic [31:0] K_FMIX2  = 32'hc2b2ae35;
   localparam int SETTLE_CYCLES     = 16;
   localparam int RANDOM_ITEMS      = 1300;
   localparam int CYCLE_LIMIT       = 800000;
   localparam int MAX_REPORTS       = 10;

   logic        clock;
   logic        reset;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_last;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] rsp_hash;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   // bench copy of the hash state
   logic [31:0] seed_q;
   logic [31:0] acc_hash;
   logic [23:0] part_block;
   logic [1:0]  byte_cnt;
   logic [31:0] msg_len;
   logic        msg_open;

   logic [31:0] expected_hash_q[$];
   int          mismatches;
   int          items_sent;
   int          cycle_count;
   bit          tx_gaps_on;
   bit          rx_stalls_on;
   int          hold_request;

   murmur3_byte_stream_hash_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last      (req_last),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rsp_hash      (rsp_hash),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] scramble_word(input logic [31:0] k);
      logic [31:0] t;
      t = k * K_MUL1;
      t = rotl32(t, 15);
      return t * K_MUL2;
   endfunction

   function automatic logic [31:0] avalanche(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * K_FMIX1;
      t = t ^ (t >> 13);
      t = t * K_FMIX2;
      return t ^ (t >> 16);
   endfunction

   task automatic restart_message();
      acc_hash   = seed_q;
      part_block = '0;
      byte_cnt   = '0;
      msg_len    = '0;
      msg_open   = 1'b0;
   endtask

   // fold one accepted item into the bench state, queue a hash on last
   task automatic absorb_item(input logic [7:0] d, input logic has, input logic lst);
      logic [31:0] h;
      if (has) begin
         msg_open = 1'b1;
         msg_len  = msg_len + 32'd1;
         if (byte_cnt == 2'd3) begin
            acc_hash   = acc_hash ^ scramble_word({d, part_block});
            acc_hash   = rotl32(acc_hash, 13);
            acc_hash   = acc_hash * 32'd5 + K_ADD;
            part_block = '0;
            byte_cnt   = '0;
         end else begin
            part_block = part_block | (24'(d) << (8 * byte_cnt));
            byte_cnt   = byte_cnt + 2'd1;
         end
      end
      if (lst) begin
         h = acc_hash;
         if (byte_cnt != 2'd0)
            h = h ^ scramble_word({8'h00, part_block});
         h = h ^ msg_len;
         expected_hash_q.push_back(avalanche(h));
         restart_message();
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (!tx_gaps_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input logic [7:0] d, input logic has, input logic lst);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data_byte <= d;
      req_has_byte  <= has;
      req_last      <= lst;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_item(d, has, lst);
      if (has || lst)
         items_sent++;
   endtask

   // stop offering, wait for every hash, then let any block mixing finish
   task automatic end_phase();
      req_valid <= 1'b0;
      while (expected_hash_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      seed_q = value;
      // a new seed only reloads the hash when no byte has been taken yet
      if (!msg_open)
         acc_hash = seed_q;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_message(input int len, input bit end_on_byte, input bit noisy);
      for (int i = 0; i < len; i++) begin
         if (noisy && $urandom_range(0, 99) < 5)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (end_on_byte && i == len - 1));
      end
      if (!end_on_byte || len == 0)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic test_directed_basics();
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      // three leftover bytes, closed by an empty last with data bits set
      repeat (3) send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1);
      // one full block, ignored item, then empty last with no leftover
      repeat (4) send_item(8'hff, 1'b1, 1'b0);
      send_item(8'ha5, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7f, 1'b1, 1'b0);
      send_item(8'hfe, 1'b1, 1'b0);
      send_item(8'h55, 1'b1, 1'b1);
      end_phase();
   endtask

   task automatic test_seed_extremes();
      logic [31:0] seeds[3];
      seeds = '{32'hffffffff, 32'h80000000, 32'h00000000};
      foreach (seeds[i]) begin
         write_seed(~seeds[i]);
         write_seed(seeds[i]);
         send_item(8'h00, 1'b0, 1'b1);
         send_item(8'($urandom), 1'b1, 1'b1);
         end_phase();
      end
   endtask

   task automatic test_seed_mid_message();
      write_seed(32'h12345678);
      send_item(8'h31, 1'b1, 1'b0);
      send_item(8'h32, 1'b1, 1'b0);
      end_phase();
      // message in progress keeps the old seed
      write_seed(32'hdeadbeef);
      send_item(8'h33, 1'b1, 1'b0);
      send_item(8'h34, 1'b1, 1'b1);
      // only ignored items so far, so the write reloads at once
      send_item(8'hc3, 1'b0, 1'b0);
      end_phase();
      write_seed(32'h0badf00d);
      send_item(8'h00, 1'b0, 1'b1);
      end_phase();
   endtask

   task automatic test_result_backpressure();
      tx_gaps_on   = 1'b0;
      hold_request = 300;
      repeat (12) send_message($urandom_range(3, 9), $urandom_range(0, 1), 1'b0);
      end_phase();
      tx_gaps_on   = 1'b1;
   endtask

   task automatic test_random_messages();
      int target;
      int r;
      int len;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            len = $urandom_range(0, 12);
         else if (r < 95)
            len = $urandom_range(13, 40);
         else
            len = $urandom_range(41, 80);
         if ($urandom_range(0, 99) < 8)
            tx_gaps_on = ~tx_gaps_on;
         if ($urandom_range(0, 99) < 8)
            rx_stalls_on = ~rx_stalls_on;
         if ($urandom_range(0, 99) < 4) begin
            end_phase();
            r = $urandom_range(0, 3);
            if (r == 0)
               write_seed(32'h00000000);
            else if (r == 1)
               write_seed(32'hffffffff);
            else
               write_seed($urandom);
         end
         send_message(len, $urandom_range(0, 1), 1'b1);
      end
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      end_phase();
   endtask

   // result side: random stalls, plus a long hold when one is requested
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!rx_stalls_on) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < 15) begin
            rsp_ready <= 1'b0;
            if ($urandom_range(0, 99) < 90)
               stall_left = $urandom_range(0, 2);
            else
               stall_left = $urandom_range(10, 40);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hash_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected hash item: got %08h", rsp_hash);
         end else begin
            if (rsp_hash !== expected_hash_q[0]) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("hash mismatch: expected %08h, got %08h",
                           expected_hash_q[0], rsp_hash);
            end
            void'(expected_hash_q.pop_front());
         end
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("** murmur3_byte_stream_hash_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_data_byte <= '0;
      req_has_byte  <= 1'b0;
      req_last      <= 1'b0;
      req_valid     <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      mismatches    = 0;
      items_sent    = 0;
      tx_gaps_on    = 1'b1;
      rx_stalls_on  = 1'b1;
      hold_request  = 0;
      seed_q        = '0;
      restart_message();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basics();
      test_seed_extremes();
      test_seed_mid_message();
      test_result_backpressure();
      test_random_messages();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_hash_q.size() == 0)
         $display("** murmur3_byte_stream_hash_unit: PASSED **");
      else
         $display("** murmur3_byte_stream_hash_unit: FAILED **");
      $finish;
   end

endmodule
